/* rtl/core/egcd_pkg.sv */
// Shared constants and control/status types for the extended GCD core.
// No dependencies.
`timescale 1ns / 1ps
package egcd_pkg;
    localparam int DATA_WIDTH_DEFAULT = 32;

    typedef struct packed {
        logic load;      // capture operands, start first division if second is nonzero
        logic div_start; // start a division of a_prev by a_cur
        logic update;    // apply quotient to the recurrence rows
        logic mul_step;  // run one multiply step
        logic finish;    // capture result into output register
    } egcd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic zero_in;
        logic mul_done;
    } egcd_status_t;
endpackage

/* rtl/core/egcd_ctrl.sv */
// Controller state machine for the extended GCD core.
// Depends on egcd_pkg.
`timescale 1ns / 1ps
module egcd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  out_busy,
    input  egcd_pkg::egcd_status_t status,
    output egcd_pkg::egcd_cmd_t   cmd,
    output logic                  idle
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        idle = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.zero_in)
                    state_next = ST_DONE;
                else if (status.div_done)
                begin
                    if (status.rem_zero)
                        state_next = ST_DONE;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_done)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

/* rtl/core/egcd_div.sv */
// Restoring radix-2 truncating signed divider, one quotient bit per cycle.
// Depends on egcd_pkg for the default width.
`timescale 1ns / 1ps
module egcd_div
#(
    parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] q_reg, b_reg;
    logic [DATA_WIDTH-1:0] r_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg, done_reg, qneg_reg, rneg_reg;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0] am, bm;

    assign am = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign bm = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;
    assign trial = {r_reg, q_reg[DATA_WIDTH-1]};
    assign diff = trial - {1'b0, b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DATA_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder stays below the divisor magnitude, so it fits in
    // DATA_WIDTH bits after every step.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= am;
            b_reg    <= bm;
            r_reg    <= '0;
            qneg_reg <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
            rneg_reg <= dividend[DATA_WIDTH-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_WIDTH])
            begin
                r_reg <= diff[DATA_WIDTH-1:0];
                q_reg <= {q_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[DATA_WIDTH-1:0];
                q_reg <= {q_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quotient = qneg_reg ? (~q_reg + 1'b1) : q_reg;
    assign remainder = rneg_reg ? (~r_reg + 1'b1) : r_reg;
endmodule

/* rtl/core/egcd_datapath.sv */
// Datapath for the extended GCD core: recurrence rows, divider, multiplies.
// Depends on egcd_pkg and egcd_div.
`timescale 1ns / 1ps
module egcd_datapath
#(
    parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  egcd_pkg::egcd_cmd_t    cmd,
    output egcd_pkg::egcd_status_t status,
    input  logic [DATA_WIDTH-1:0]  first_in,
    input  logic [DATA_WIDTH-1:0]  second_in,
    output logic [DATA_WIDTH-1:0]  res_a,
    output logic [DATA_WIDTH-1:0]  res_x,
    output logic [DATA_WIDTH-1:0]  res_y,
    output logic                   res_zero
);
    localparam int HW = (DATA_WIDTH + 1) / 2;

    logic [DATA_WIDTH-1:0] ac_reg, xp_reg, xc_reg, yp_reg, yc_reg;
    logic [DATA_WIDTH-1:0] px_reg, py_reg;
    logic                  zero_reg, ph_reg;
    logic                  div_start;
    logic                  div_done;
    logic [DATA_WIDTH-1:0] q, r;
    logic [HW-1:0]         qpart;
    logic [DATA_WIDTH-1:0] qext, mx, my;

    // The previous row's value only feeds the divider, which holds it.
    assign div_start = cmd.div_start || (cmd.load && (second_in != '0));

    egcd_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (cmd.load ? first_in : ac_reg),
        .divisor   (cmd.load ? second_in : r),
        .done      (div_done),
        .quotient  (q),
        .remainder (r)
    );

    // Two half-width partial products per coefficient, low half first.
    assign qpart = ph_reg ? HW'(q >> HW) : q[HW-1:0];
    assign qext = DATA_WIDTH'(qpart);
    assign mx = DATA_WIDTH'(qext * (ph_reg ? (xc_reg << HW) : xc_reg));
    assign my = DATA_WIDTH'(qext * (ph_reg ? (yc_reg << HW) : yc_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_reg <= 1'b0;
        else if (cmd.mul_step)
            ph_reg <= ~ph_reg;
        else
            ph_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ac_reg   <= second_in;
            xp_reg   <= DATA_WIDTH'(1);
            xc_reg   <= '0;
            yp_reg   <= '0;
            yc_reg   <= DATA_WIDTH'(1);
            zero_reg <= (second_in == '0);
        end
        else if (cmd.mul_step)
        begin
            if (!ph_reg)
            begin
                px_reg <= mx;
                py_reg <= my;
            end
            else
            begin
                px_reg <= px_reg + mx;
                py_reg <= py_reg + my;
            end
        end
        else if (cmd.update)
        begin
            ac_reg <= r;
            xp_reg <= xc_reg;
            xc_reg <= xp_reg - px_reg;
            yp_reg <= yc_reg;
            yc_reg <= yp_reg - py_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.rem_zero = (r == '0);
    assign status.zero_in  = zero_reg;
    assign status.mul_done = ph_reg;
    assign res_a    = zero_reg ? '0 : ac_reg;
    assign res_x    = zero_reg ? '0 : xc_reg;
    assign res_y    = zero_reg ? '0 : yc_reg;
    assign res_zero = zero_reg;
endmodule

/* rtl/core/extended_gcd_core.sv */
// Top level of the extended GCD core: controller, datapath, output register.
// Depends on egcd_pkg, egcd_ctrl, egcd_datapath.
//
// Usage:
//   Input channel (valid/ready) carries one word: first_value, second_value.
//   Output channel (valid/ready) carries divisor, coef_first, coef_second
//   and zero_divisor, with divisor = coef_first*first + coef_second*second
//   modulo 2^DATA_WIDTH. A zero second_value raises zero_divisor and gives
//   zeros elsewhere.
//   Each Euclid step runs one shared radix-2 divider, then two half-width
//   multiply steps and one update step; about 46 Euclid steps worst case
//   at 32 bits. One word is in flight at a time.
//   The result sits in an output register; the next word is accepted while
//   it waits. If the receiver stalls with a second result ready, the core
//   holds that result internally until the output register frees.
//   Reset clears the controller and the output valid; no word is pending.
`timescale 1ns / 1ps
module extended_gcd_core
#(
    parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] first_value,
    input  logic [DATA_WIDTH-1:0] second_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] divisor,
    output logic [DATA_WIDTH-1:0] coef_first,
    output logic [DATA_WIDTH-1:0] coef_second,
    output logic                  zero_divisor
);
    egcd_pkg::egcd_cmd_t    cmd;
    egcd_pkg::egcd_status_t status;
    logic                   idle;
    logic                   out_valid_reg;
    logic [DATA_WIDTH-1:0]  div_reg, cf_reg, cs_reg;
    logic                   zd_reg;
    logic [DATA_WIDTH-1:0]  res_a, res_x, res_y;
    logic                   res_zero;

    assign in_ready = idle;

    egcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_valid && idle),
        .out_busy (out_valid_reg && !out_ready),
        .status   (status),
        .cmd      (cmd),
        .idle     (idle)
    );

    egcd_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .first_in  (first_value),
        .second_in (second_value),
        .res_a     (res_a),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_zero  (res_zero)
    );

    // Hold the result until taken; load a new one on finish.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            div_reg <= res_a;
            cf_reg  <= res_x;
            cs_reg  <= res_y;
            zd_reg  <= res_zero;
        end
    end

    assign out_valid    = out_valid_reg;
    assign divisor      = div_reg;
    assign coef_first   = cf_reg;
    assign coef_second  = cs_reg;
    assign zero_divisor = zd_reg;
endmodule

/* bench/extended_gcd_core_tb.sv */
// Self-checking bench for extended_gcd_core: signed extended Euclid with Bezout
// coefficients, checked word by word against an in-bench recurrence model.
// Depends on egcd_pkg and the extended_gcd_core RTL.
`timescale 1ns / 1ps

// Ordered store of predicted results; notes accepted operand pairs and checks
// every result word that leaves the core.
class gcd_scoreboard;
    localparam int W = egcd_pkg::DATA_WIDTH_DEFAULT;

    typedef struct packed {
        logic [W-1:0] gcd;
        logic [W-1:0] cf;
        logic [W-1:0] cs;
        logic         zflag;
    } gcd_result_t;

    gcd_result_t pending_results[$];
    int          error_count;

    function new();
        error_count = 0;
    endfunction

    // Truncating signed division built from unsigned magnitudes, so the most
    // negative operand divides without trapping.
    static function void trunc_divrem(input logic [W-1:0] a, input logic [W-1:0] b,
                                      output logic [W-1:0] q, output logic [W-1:0] r);
        logic [W-1:0] am;
        logic [W-1:0] bm;
        logic [W-1:0] qm;
        logic [W-1:0] rm;
        am = a[W-1] ? -a : a;
        bm = b[W-1] ? -b : b;
        qm = am / bm;
        rm = am % bm;
        q = (a[W-1] != b[W-1]) ? -qm : qm;
        r = a[W-1] ? -rm : rm;
    endfunction

    static function gcd_result_t bezout(input logic [W-1:0] first, input logic [W-1:0] second);
        gcd_result_t  res;
        logic [W-1:0] ap;
        logic [W-1:0] ac;
        logic [W-1:0] xp;
        logic [W-1:0] xc;
        logic [W-1:0] yp;
        logic [W-1:0] yc;
        logic [W-1:0] q;
        logic [W-1:0] r;
        logic [W-1:0] t;
        res = '0;
        if (second == '0)
        begin
            res.zflag = 1'b1;
            return res;
        end
        ap = first;
        ac = second;
        xp = 1;
        xc = 0;
        yp = 0;
        yc = 1;
        trunc_divrem(ap, ac, q, r);
        while (r != '0)
        begin
            ap = ac;
            ac = r;
            t = xp - q * xc;
            xp = xc;
            xc = t;
            t = yp - q * yc;
            yp = yc;
            yc = t;
            trunc_divrem(ap, ac, q, r);
        end
        res.gcd = ac;
        res.cf = xc;
        res.cs = yc;
        return res;
    endfunction

    function void note_operands(input logic [W-1:0] first, input logic [W-1:0] second);
        pending_results.push_back(bezout(first, second));
    endfunction

    function void report_mismatch(input string what, input logic [W-1:0] got,
                                  input logic [W-1:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        error_count++;
    endfunction

    function void check_result(input gcd_result_t got);
        gcd_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result word", got.gcd, '0);
            return;
        end
        want = pending_results.pop_front();
        if (got.gcd !== want.gcd) report_mismatch("divisor", got.gcd, want.gcd);
        if (got.cf !== want.cf) report_mismatch("coef_first", got.cf, want.cf);
        if (got.cs !== want.cs) report_mismatch("coef_second", got.cs, want.cs);
        if (got.zflag !== want.zflag)
            report_mismatch("zero_divisor", W'(got.zflag), W'(want.zflag));
    endfunction
endclass

module extended_gcd_core_tb;
    localparam int W = egcd_pkg::DATA_WIDTH_DEFAULT;
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_ready;
    logic [W-1:0] first_value = '0;
    logic [W-1:0] second_value = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    logic [W-1:0] divisor;
    logic [W-1:0] coef_first;
    logic [W-1:0] coef_second;
    logic         zero_divisor;

    // Idle rates in percent; the stimulus process changes them by phase.
    int send_idle_pct = 7;
    int recv_idle_pct = 80;
    bit recv_idle;

    gcd_scoreboard board = new();

    always #5 clk = ~clk;

    extended_gcd_core #(.DATA_WIDTH(W)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .first_value(first_value), .second_value(second_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .divisor(divisor), .coef_first(coef_first),
        .coef_second(coef_second), .zero_divisor(zero_divisor)
    );

    // Drain side: check each accepted result word, then decide the next
    // cycle's ready from the current idle rate.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({divisor, coef_first, coef_second, zero_divisor});
        recv_idle = ($urandom_range(99) < recv_idle_pct);
        out_ready <= rst_n && !recv_idle;
    end

    // Present one operand word and hold it until the core takes it; random
    // idle cycles go in ahead of the word. Valid stays up after the accept
    // so a following word goes back to back; the caller drops it at the end.
    task automatic send_word(input logic [W-1:0] a, input logic [W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        first_value <= a;
        second_value <= b;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_operands(a, b);
    endtask

    // Mix of full-range, small and structured operands so long and short
    // remainder chains, sign mixes and shared factors all appear.
    function automatic logic [W-1:0] random_operand();
        logic [W-1:0] v;
        case ($urandom_range(5))
            0: v = $urandom_range(20);
            1: v = -$urandom_range(20);
            2: v = $urandom_range(1000) * $urandom_range(1, 64);
            3: v = $urandom & ({W{1'b1}} >> $urandom_range(W - 1));
            4: v = $urandom_range(1) ? MOST_NEG : MOST_POS;
            default: v = $urandom;
        endcase
        if ($urandom_range(1) && v != MOST_NEG) v = -v;
        return v;
    endfunction

    task automatic send_random(input int count);
        logic [W-1:0] a;
        logic [W-1:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = random_operand();
            b = ($urandom_range(19) == 0) ? '0 : random_operand();
            send_word(a, b);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero second operand, zero first operand, extremes,
        // every sign mix, Fibonacci neighbors for the longest chain.
        send_word(32'd12, '0);
        send_word('0, '0);
        send_word('0, 32'd7);
        send_word('0, -32'sd7);
        send_word(MOST_NEG, MOST_NEG);
        send_word(MOST_NEG, 32'd1);
        send_word(MOST_NEG, -32'sd1);
        send_word(MOST_POS, MOST_NEG);
        send_word(MOST_NEG, MOST_POS);
        send_word(MOST_POS, MOST_POS);
        send_word({W{1'b1}}, {W{1'b1}});
        send_word(32'd240, 32'd46);
        send_word(-32'sd240, 32'd46);
        send_word(32'd240, -32'sd46);
        send_word(-32'sd240, -32'sd46);
        send_word(32'd1836311903, 32'd1134903170);
        send_word(-32'sd1836311903, 32'd1134903170);
        send_word(32'd1, MOST_POS);
        send_word(32'hAAAA_AAAA, 32'h5555_5555);
        send_word(32'h5555_5555, 32'hAAAA_AAAA);

        send_random(130);
        send_idle_pct = 80;
        recv_idle_pct = 7;
        send_random(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(130);
        in_valid <= 1'b0;

        // Wait for the last results, then give the core a short tail.
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.error_count == 0)
            $display("extended_gcd_core regression: pass");
        else
            $display("extended_gcd_core regression: fail");
        $finish;
    end

    // Watchdog: fails the run if the 410 words have not all drained by the
    // timeout, which leaves room for stalls and margin.
    initial
    begin
        #(15_000_000 * 10);
        $display("extended_gcd_core regression: fail");
        $finish;
    end
endmodule

/* extended_gcd_core.f */
rtl/core/egcd_pkg.sv
rtl/core/egcd_ctrl.sv
rtl/core/egcd_div.sv
rtl/core/egcd_datapath.sv
rtl/core/extended_gcd_core.sv
bench/extended_gcd_core_tb.sv
